// ===== hw/rtl/scaled_font_text_renderer_top_macros.svh =====
// assertion macros for the text renderer checker
`ifndef SCALED_FONT_TEXT_RENDERER_TOP_MACROS_SVH
`define SCALED_FONT_TEXT_RENDERER_TOP_MACROS_SVH

// same-cycle implication
`define SFTR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sftr assertion failed");

// next-cycle implication
`define SFTR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sftr assertion failed");

`endif

// ===== hw/rtl/sftr_pkg.sv =====
// shared types, command codes and font tables of the text renderer
package sftr_pkg;

    localparam logic [2:0] CMD_CLEAR = 3'd0;
    localparam logic [2:0] CMD_PIXEL = 3'd1;
    localparam logic [2:0] CMD_TEXT  = 3'd2;
    localparam logic [2:0] CMD_DRAW  = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    typedef struct packed {
        logic latch;
        logic wipe;
        logic text_load;
        logic rmw_wr;
        logic step;
        logic glyph_done;
        logic host_rd;
        logic read_cap;
    } ctl_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       fit;
        logic       wipe_last;
        logic       rmw_last;
    } sts_t;

    localparam logic [2:0] GLYPH_W [4] = '{3'd3, 3'd4, 3'd5, 3'd6};
    localparam logic [3:0] GLYPH_H [4] = '{4'd6, 4'd8, 4'd10, 4'd12};

    localparam logic [2:0] SRC_COL [4][8] = '{
        '{3'd0, 3'd1, 3'd3, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd0, 3'd0},
        '{3'd0, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd0}
    };

    localparam logic [2:0] SRC_ROW [4][16] = '{
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd0, 3'd0,
          3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd0, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6,
          3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd0, 3'd0, 3'd1, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4,
          3'd5, 3'd6, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd0, 3'd0, 3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd4,
          3'd4, 3'd5, 3'd5, 3'd6, 3'd0, 3'd0, 3'd0, 3'd0}
    };

    localparam logic [7:0] FONT_ROM [72][5] = '{
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h08, 8'h08, 8'h08, 8'h08, 8'h08}, '{8'h00, 8'h60, 8'h60, 8'h00, 8'h00},
        '{8'h63, 8'h13, 8'h08, 8'h64, 8'h63}, '{8'h00, 8'h36, 8'h36, 8'h00, 8'h00},
        '{8'h60, 8'h18, 8'h06, 8'h01, 8'h00}, '{8'h08, 8'h08, 8'h3e, 8'h08, 8'h08},
        '{8'h00, 8'h00, 8'h5f, 8'h00, 8'h00}, '{8'h02, 8'h01, 8'h51, 8'h09, 8'h06},
        '{8'h40, 8'h40, 8'h40, 8'h40, 8'h40},
        '{8'h3e, 8'h51, 8'h49, 8'h45, 8'h3e}, '{8'h00, 8'h42, 8'h7f, 8'h40, 8'h00},
        '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46}, '{8'h21, 8'h41, 8'h45, 8'h4b, 8'h31},
        '{8'h18, 8'h14, 8'h12, 8'h7f, 8'h10}, '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
        '{8'h3c, 8'h4a, 8'h49, 8'h49, 8'h30}, '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
        '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1e},
        '{8'h7e, 8'h11, 8'h11, 8'h11, 8'h7e}, '{8'h7f, 8'h49, 8'h49, 8'h49, 8'h36},
        '{8'h3e, 8'h41, 8'h41, 8'h41, 8'h22}, '{8'h7f, 8'h41, 8'h41, 8'h22, 8'h1c},
        '{8'h7f, 8'h49, 8'h49, 8'h49, 8'h41}, '{8'h7f, 8'h09, 8'h09, 8'h09, 8'h01},
        '{8'h3e, 8'h41, 8'h49, 8'h49, 8'h7a}, '{8'h7f, 8'h08, 8'h08, 8'h08, 8'h7f},
        '{8'h00, 8'h41, 8'h7f, 8'h41, 8'h00}, '{8'h20, 8'h40, 8'h41, 8'h3f, 8'h01},
        '{8'h7f, 8'h08, 8'h14, 8'h22, 8'h41}, '{8'h7f, 8'h40, 8'h40, 8'h40, 8'h40},
        '{8'h7f, 8'h02, 8'h0c, 8'h02, 8'h7f}, '{8'h7f, 8'h04, 8'h08, 8'h10, 8'h7f},
        '{8'h3e, 8'h41, 8'h41, 8'h41, 8'h3e}, '{8'h7f, 8'h09, 8'h09, 8'h09, 8'h06},
        '{8'h3e, 8'h41, 8'h51, 8'h21, 8'h5e}, '{8'h7f, 8'h09, 8'h19, 8'h29, 8'h46},
        '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31}, '{8'h01, 8'h01, 8'h7f, 8'h01, 8'h01},
        '{8'h3f, 8'h40, 8'h40, 8'h40, 8'h3f}, '{8'h1f, 8'h20, 8'h40, 8'h20, 8'h1f},
        '{8'h3f, 8'h40, 8'h38, 8'h40, 8'h3f}, '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
        '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07}, '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43},
        '{8'h20, 8'h54, 8'h54, 8'h54, 8'h78}, '{8'h7f, 8'h48, 8'h44, 8'h44, 8'h38},
        '{8'h38, 8'h44, 8'h44, 8'h44, 8'h20}, '{8'h38, 8'h44, 8'h44, 8'h48, 8'h7f},
        '{8'h38, 8'h54, 8'h54, 8'h54, 8'h18}, '{8'h08, 8'h7e, 8'h09, 8'h01, 8'h02},
        '{8'h0c, 8'h52, 8'h52, 8'h52, 8'h3e}, '{8'h7f, 8'h08, 8'h04, 8'h04, 8'h78},
        '{8'h00, 8'h44, 8'h7d, 8'h40, 8'h00}, '{8'h20, 8'h40, 8'h44, 8'h3d, 8'h00},
        '{8'h7f, 8'h10, 8'h28, 8'h44, 8'h00}, '{8'h00, 8'h41, 8'h7f, 8'h40, 8'h00},
        '{8'h7c, 8'h04, 8'h18, 8'h04, 8'h78}, '{8'h7c, 8'h08, 8'h04, 8'h04, 8'h78},
        '{8'h38, 8'h44, 8'h44, 8'h44, 8'h38}, '{8'h7c, 8'h14, 8'h14, 8'h14, 8'h08},
        '{8'h08, 8'h14, 8'h14, 8'h18, 8'h7c}, '{8'h7c, 8'h08, 8'h04, 8'h04, 8'h08},
        '{8'h48, 8'h54, 8'h54, 8'h54, 8'h20}, '{8'h04, 8'h3f, 8'h44, 8'h40, 8'h20},
        '{8'h3c, 8'h40, 8'h40, 8'h20, 8'h7c}, '{8'h1c, 8'h20, 8'h40, 8'h20, 8'h1c},
        '{8'h3c, 8'h40, 8'h30, 8'h40, 8'h3c}, '{8'h44, 8'h28, 8'h10, 8'h28, 8'h44},
        '{8'h0c, 8'h50, 8'h50, 8'h50, 8'h3c}, '{8'h44, 8'h64, 8'h54, 8'h4c, 8'h44}
    };

    function automatic logic [6:0] rom_index(input logic [7:0] c);
        logic [6:0] idx;
        idx = 7'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            idx = 7'(c - 8'h30) + 7'd10;
        end
        else if (c >= 8'h41 && c <= 8'h5a) begin
            idx = 7'(c - 8'h41) + 7'd20;
        end
        else if (c >= 8'h61 && c <= 8'h7a) begin
            idx = 7'(c - 8'h61) + 7'd46;
        end
        else begin
            unique case (c)
                8'h2d:   idx = 7'd1;
                8'h2e:   idx = 7'd2;
                8'h25:   idx = 7'd3;
                8'h3a:   idx = 7'd4;
                8'h2f:   idx = 7'd5;
                8'h2b:   idx = 7'd6;
                8'h21:   idx = 7'd7;
                8'h3f:   idx = 7'd8;
                8'h5f:   idx = 7'd9;
                default: idx = 7'd0;
            endcase
        end
        return idx;
    endfunction

endpackage

// ===== hw/rtl/sftr_datapath.sv =====
// framebuffer memory, text state, glyph sampling and read-modify-write datapath
module sftr_datapath
    import sftr_pkg::*;
#(
    parameter int DISPLAY_WIDTH  = 128,
    parameter int DISPLAY_HEIGHT = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctl_t              ctl,
    output sts_t              sts,
    input  logic [2:0]        command,
    input  logic signed [8:0] x_pos,
    input  logic signed [8:0] y_pos,
    input  logic [1:0]        font_size,
    input  logic [8:0]        clip_width,
    input  logic [7:0]        char_code,
    input  logic [9:0]        read_address,
    output logic [7:0]        read_data,
    output logic              drawn
);

    localparam int PAGES       = (DISPLAY_HEIGHT + 7) / 8;
    localparam int STORE_BYTES = DISPLAY_WIDTH * PAGES;
    localparam int ADDR_W      = $clog2(STORE_BYTES);

    logic [7:0] mem [STORE_BYTES];
    logic [7:0] rdata_reg;

    logic [2:0]        cmd_reg;
    logic signed [8:0] x_reg;
    logic signed [8:0] y_reg;
    logic [1:0]        size_reg;
    logic [8:0]        clip_reg;
    logic [6:0]        gidx_reg;
    logic [9:0]        raddr_reg;

    logic signed [10:0] cursor_reg;
    logic signed [10:0] cursor_next;
    logic signed [9:0]  top_reg;
    logic [1:0]         font_reg;
    logic signed [10:0] limit_reg;

    logic [2:0]        col_reg;
    logic [1:0]        pg_reg;
    logic [ADDR_W-1:0] clr_reg;
    logic [7:0]        read_data_reg;
    logic              drawn_reg;

    logic               plot;
    logic [2:0]         gw;
    logic [3:0]         gh;
    logic               page_last;
    logic               col_last;
    logic signed [10:0] xcol;
    logic signed [9:0]  y0;
    logic signed [9:0]  page;
    logic               in_range;
    logic [ADDR_W-1:0]  rmw_addr;
    logic [7:0]         colbits;
    logic [7:0]         mask;
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [ADDR_W-1:0]  raddr;
    logic [7:0]         wdata;

    assign plot      = (cmd_reg == CMD_PIXEL);
    assign gw        = GLYPH_W[font_reg];
    assign gh        = GLYPH_H[font_reg];
    assign page_last = plot || (pg_reg == 2'd2);
    assign col_last  = plot || (col_reg == gw - 3'd1);

    assign xcol = plot ? 11'(x_reg) : cursor_reg + $signed(11'(col_reg));
    assign y0   = plot ? 10'(y_reg) : top_reg;
    assign page = (y0 >>> 3) + $signed(10'(pg_reg));

    assign in_range = (xcol >= 0) && (xcol < DISPLAY_WIDTH) && (page >= 0) && (page < PAGES);
    assign rmw_addr = ADDR_W'(xcol[7:0]) + ADDR_W'(page[3:0]) * ADDR_W'(DISPLAY_WIDTH);
    assign colbits  = FONT_ROM[gidx_reg][SRC_COL[font_reg][col_reg]];

    always_comb
    begin
        logic signed [12:0] yrow;
        logic signed [12:0] rdiff;
        for (int b = 0; b < 8; b++) begin
            yrow  = $signed({page, 3'(b)});
            rdiff = yrow - 13'(y0);
            if (rdiff < 0 || yrow >= DISPLAY_HEIGHT) begin
                mask[b] = 1'b0;
            end
            else if (plot) begin
                mask[b] = (rdiff == 0);
            end
            else begin
                mask[b] = (rdiff < $signed(13'(gh)))
                       && colbits[SRC_ROW[font_reg][rdiff[3:0]]];
            end
        end
    end

    assign we    = ctl.wipe || (ctl.rmw_wr && in_range);
    assign waddr = ctl.wipe ? clr_reg : rmw_addr;
    assign wdata = ctl.wipe ? 8'h00 : (rdata_reg | mask);
    assign raddr = ctl.host_rd ? ADDR_W'(raddr_reg) : rmw_addr;

    always_ff @(posedge clk)
    begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.latch) begin
            cmd_reg   <= command;
            x_reg     <= x_pos;
            y_reg     <= y_pos;
            size_reg  <= font_size;
            clip_reg  <= clip_width;
            gidx_reg  <= rom_index(char_code);
            raddr_reg <= read_address;
        end
    end

    assign cursor_next = cursor_reg + $signed(11'(gw)) + 11'sd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cursor_reg    <= '0;
            top_reg       <= '0;
            font_reg      <= '0;
            limit_reg     <= '0;
            col_reg       <= '0;
            pg_reg        <= '0;
            clr_reg       <= '0;
            read_data_reg <= '0;
            drawn_reg     <= 1'b0;
        end
        else begin
            if (ctl.latch) begin
                col_reg       <= '0;
                pg_reg        <= '0;
                clr_reg       <= '0;
                read_data_reg <= '0;
                drawn_reg     <= 1'b0;
            end
            if (ctl.wipe) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (ctl.text_load) begin
                cursor_reg <= 11'(x_reg);
                top_reg    <= 10'(y_reg);
                font_reg   <= size_reg;
                limit_reg  <= 11'(x_reg) + $signed(11'(clip_reg));
            end
            if (ctl.step) begin
                if (page_last) begin
                    pg_reg  <= '0;
                    col_reg <= col_reg + 3'd1;
                end
                else begin
                    pg_reg <= pg_reg + 2'd1;
                end
            end
            if (ctl.glyph_done) begin
                cursor_reg <= cursor_next;
                drawn_reg  <= 1'b1;
            end
            if (ctl.read_cap) begin
                read_data_reg <= (raddr_reg < STORE_BYTES) ? rdata_reg : 8'h00;
            end
        end
    end

    assign sts.cmd       = cmd_reg;
    assign sts.fit       = ($signed(12'(cursor_reg)) + $signed(12'(gw)))
                           <= $signed(12'(limit_reg));
    assign sts.wipe_last = (clr_reg == ADDR_W'(STORE_BYTES - 1));
    assign sts.rmw_last  = page_last && col_last;

    assign read_data = read_data_reg;
    assign drawn     = drawn_reg;

endmodule

// ===== hw/rtl/sftr_ctrl.sv =====
// command sequencer state machine of the text renderer
module sftr_ctrl
    import sftr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  sts_t sts,
    output ctl_t ctl,
    output logic busy,
    output logic done
);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_WIPE      = 9'b000000010,
        S_DISPATCH  = 9'b000000100,
        S_CLEAR     = 9'b000001000,
        S_RMW_RD    = 9'b000010000,
        S_RMW_WR    = 9'b000100000,
        S_READ_RD   = 9'b001000000,
        S_READ_WAIT = 9'b010000000,
        S_DONE      = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start) begin
                    ctl.latch  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_WIPE:
            begin
                ctl.wipe = 1'b1;
                if (sts.wipe_last) begin
                    state_next = S_IDLE;
                end
            end
            S_DISPATCH:
            begin
                unique case (sts.cmd)
                    CMD_CLEAR: state_next = S_CLEAR;
                    CMD_PIXEL: state_next = S_RMW_RD;
                    CMD_TEXT:
                    begin
                        ctl.text_load = 1'b1;
                        state_next    = S_DONE;
                    end
                    CMD_DRAW:  state_next = sts.fit ? S_RMW_RD : S_DONE;
                    CMD_READ:  state_next = S_READ_RD;
                    default:   state_next = S_DONE;
                endcase
            end
            S_CLEAR:
            begin
                ctl.wipe = 1'b1;
                if (sts.wipe_last) begin
                    state_next = S_DONE;
                end
            end
            S_RMW_RD:
            begin
                state_next = S_RMW_WR;
            end
            S_RMW_WR:
            begin
                ctl.rmw_wr = 1'b1;
                if (sts.rmw_last) begin
                    ctl.glyph_done = (sts.cmd == CMD_DRAW);
                    state_next     = S_DONE;
                end
                else begin
                    ctl.step   = 1'b1;
                    state_next = S_RMW_RD;
                end
            end
            S_READ_RD:
            begin
                ctl.host_rd = 1'b1;
                state_next  = S_READ_WAIT;
            end
            S_READ_WAIT:
            begin
                ctl.read_cap = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_WIPE;
        end
        else begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

// ===== hw/rtl/scaled_font_text_renderer_top.sv =====
// top level of the scaled 5x7 font text renderer
//
// channel   signals                                             handshake
// command   command x_pos y_pos font_size clip_width            start && !busy
//           char_code read_address
// result    read_data drawn                                     done, one cycle
//
// every item gives one result: S_IDLE latches the item, S_DISPATCH decodes it, S_DONE
// shows the result; a draw (w = glyph width 3..6) read-modify-writes three pages of
// each column through the one framebuffer memory; a refused glyph or start text goes
// straight to S_DONE; clear writes all width*pages bytes (one byte written per cycle)
// after reset busy stays high while the framebuffer is wiped
// results cannot be stalled; done pulses for one cycle and busy falls after it
module scaled_font_text_renderer_top
    import sftr_pkg::*;
#(
    parameter int DISPLAY_WIDTH  = 128,
    parameter int DISPLAY_HEIGHT = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        command,
    input  logic signed [8:0] x_pos,
    input  logic signed [8:0] y_pos,
    input  logic [1:0]        font_size,
    input  logic [8:0]        clip_width,
    input  logic [7:0]        char_code,
    input  logic [9:0]        read_address,
    output logic              done,
    output logic [7:0]        read_data,
    output logic              drawn
);

    ctl_t ctl;
    sts_t sts;

    sftr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    sftr_datapath #(
        .DISPLAY_WIDTH  (DISPLAY_WIDTH),
        .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .sts          (sts),
        .command      (command),
        .x_pos        (x_pos),
        .y_pos        (y_pos),
        .font_size    (font_size),
        .clip_width   (clip_width),
        .char_code    (char_code),
        .read_address (read_address),
        .read_data    (read_data),
        .drawn        (drawn)
    );

endmodule

// ===== hw/rtl/sftr_checker.sv =====
// port-level checker of the text renderer and its bind
`include "scaled_font_text_renderer_top_macros.svh"

module sftr_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [7:0] read_data,
    input logic       drawn
);

    `SFTR_ASSERT_NOW(a_done_busy, done, busy)
    `SFTR_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done)
    `SFTR_ASSERT_NEXT(a_done_pulse, done, !done && !busy)
    `SFTR_ASSERT_NOW(a_drawn_no_data, done && drawn, read_data == 8'h00)

endmodule

bind scaled_font_text_renderer_top sftr_checker u_sftr_checker (.*);

// ===== verif/scaled_font_text_renderer_top_tb.sv =====
// self-checking testbench for the scaled font text renderer
module scaled_font_text_renderer_top_tb
    import sftr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = 128;
    localparam int DH = 64;
    localparam int STORE = DW * ((DH + 7) / 8);
    localparam int LIMIT_CYCLES = 900000;

    typedef struct packed {
        logic [7:0] read_data;
        logic       drawn;
    } render_result_t;

    class render_scoreboard;
        logic [7:0]     fb[STORE];
        int             pen_x;
        int             top_y;
        int             font;
        int             limit_x;
        render_result_t pending[$];
        int             errors;

        function new();
            foreach (fb[i]) fb[i] = '0;
            pen_x = 0;
            top_y = 0;
            font = 0;
            limit_x = 0;
            errors = 0;
        endfunction

        function void set_pixel(int px, int py);
            if (px >= 0 && px < DW && py >= 0 && py < DH)
                fb[px + (py / 8) * DW][py % 8] = 1'b1;
        endfunction

        function int glyph_index(logic [7:0] c);
            if (c >= "0" && c <= "9") return 10 + c - "0";
            if (c >= "A" && c <= "Z") return 20 + c - "A";
            if (c >= "a" && c <= "z") return 46 + c - "a";
            case (c)
                "-": return 1;
                ".": return 2;
                "%": return 3;
                ":": return 4;
                "/": return 5;
                "+": return 6;
                "!": return 7;
                "?": return 8;
                "_": return 9;
                default: return 0;
            endcase
        endfunction

        function void note_item(logic [2:0] cmd, logic signed [8:0] xp, logic signed [8:0] yp,
                                logic [1:0] fs, logic [8:0] cw, logic [7:0] ch,
                                logic [9:0] addr);
            render_result_t r;
            int w;
            int h;
            int g;
            logic [7:0] bits;
            r = '0;
            case (cmd)
                CMD_CLEAR: foreach (fb[i]) fb[i] = '0;
                CMD_PIXEL: set_pixel(int'(xp), int'(yp));
                CMD_TEXT:
                begin
                    pen_x = int'(xp);
                    top_y = int'(yp);
                    font = fs;
                    limit_x = int'(xp) + int'(cw);
                end
                CMD_DRAW:
                begin
                    w = font + 3;
                    h = 2 * font + 6;
                    if (pen_x + w <= limit_x)
                    begin
                        g = glyph_index(ch);
                        for (int c = 0; c < w; c++)
                        begin
                            bits = FONT_ROM[g][(c * 5) / w];
                            for (int rr = 0; rr < h; rr++)
                                if (bits[(rr * 7) / h])
                                    set_pixel(pen_x + c, top_y + rr);
                        end
                        pen_x += w + 1;
                        r.drawn = 1'b1;
                    end
                end
                CMD_READ: if (addr < STORE) r.read_data = fb[addr];
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(logic [7:0] rd, logic dr);
            render_result_t e;
            if (pending.size() == 0)
            begin
                $display("%0t unexpected result read_data=%h drawn=%b", $time, rd, dr);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (e.read_data !== rd)
            begin
                $display("%0t read_data expected %h actual %h", $time, e.read_data, rd);
                errors++;
            end
            if (e.drawn !== dr)
            begin
                $display("%0t drawn expected %b actual %b", $time, e.drawn, dr);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [2:0]        command;
    logic signed [8:0] x_pos;
    logic signed [8:0] y_pos;
    logic [1:0]        font_size;
    logic [8:0]        clip_width;
    logic [7:0]        char_code;
    logic [9:0]        read_address;
    logic              done;
    logic [7:0]        read_data;
    logic              drawn;

    render_scoreboard sb;
    int idle_pct;
    int cycles;

    scaled_font_text_renderer_top DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(read_data, drawn);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("scaled_font_text_renderer_top_tb: errors");
            $finish;
        end
    end

    task automatic send_item(logic [2:0] cmd, logic signed [8:0] xp, logic signed [8:0] yp,
                             logic [1:0] fs, logic [8:0] cw, logic [7:0] ch,
                             logic [9:0] addr);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        command <= cmd;
        x_pos <= xp;
        y_pos <= yp;
        font_size <= fs;
        clip_width <= cw;
        char_code <= ch;
        read_address <= addr;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_item(cmd, xp, yp, fs, cw, ch, addr);
    endtask

    task automatic send_random_item();
        int pick;
        logic [7:0] ch;
        pick = $urandom_range(99);
        if ($urandom_range(1))
            ch = "!" + 8'($urandom_range(90));
        else
            ch = 8'($urandom);
        if (pick < 2)
            send_item(CMD_CLEAR, 9'($urandom), 9'($urandom), 2'($urandom), 9'($urandom),
                      ch, 10'($urandom));
        else if (pick < 12)
            send_item(CMD_PIXEL, 9'($urandom_range(140)) - 9'sd6,
                      9'($urandom_range(76)) - 9'sd6, 2'($urandom), 9'($urandom), ch,
                      10'($urandom));
        else if (pick < 14)
            send_item(CMD_PIXEL, 9'($urandom), 9'($urandom), 2'($urandom), 9'($urandom), ch,
                      10'($urandom));
        else if (pick < 22)
            send_item(CMD_TEXT, 9'($urandom_range(150)) - 9'sd16,
                      9'($urandom_range(80)) - 9'sd12, 2'($urandom),
                      ($urandom_range(3) == 0) ? 9'($urandom) : 9'($urandom_range(60)),
                      ch, 10'($urandom));
        else if (pick < 24)
            send_item(CMD_TEXT, 9'($urandom), 9'($urandom), 2'($urandom), 9'($urandom), ch,
                      10'($urandom));
        else if (pick < 70)
            send_item(CMD_DRAW, 9'($urandom), 9'($urandom), 2'($urandom), 9'($urandom), ch,
                      10'($urandom));
        else if (pick < 97)
            send_item(CMD_READ, 9'($urandom), 9'($urandom), 2'($urandom), 9'($urandom), ch,
                      ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(STORE - 1)));
        else
            send_item(3'($urandom_range(7, 5)), 9'($urandom), 9'($urandom), 2'($urandom),
                      9'($urandom), ch, 10'($urandom));
    endtask

    initial
    begin
        sb = new();
        cycles = 0;
        idle_pct = 0;
        rst_n = 1'b0;
        start = 1'b0;
        command = CMD_CLEAR;
        x_pos = '0;
        y_pos = '0;
        font_size = '0;
        clip_width = '0;
        char_code = '0;
        read_address = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: each size, edges, clip refusal, unknown codes, reads
        send_item(CMD_PIXEL, 9'sd0, 9'sd0, 2'd0, 9'd0, 8'h00, 10'd0);
        send_item(CMD_PIXEL, 9'sd127, 9'sd63, 2'd0, 9'd0, 8'h00, 10'd0);
        send_item(CMD_PIXEL, -9'sd256, 9'sd255, 2'd3, 9'd511, 8'hff, 10'd1023);
        send_item(CMD_READ, 9'sd0, 9'sd0, 2'd0, 9'd0, 8'h00, 10'd0);
        send_item(CMD_READ, 9'sd0, 9'sd0, 2'd0, 9'd0, 8'h00, 10'd1023);
        send_item(CMD_TEXT, -9'sd2, -9'sd3, 2'd3, 9'd511, 8'h00, 10'd0);
        send_item(CMD_DRAW, 9'sd0, 9'sd0, 2'd0, 9'd0, "%", 10'd0);
        send_item(CMD_DRAW, 9'sd0, 9'sd0, 2'd0, 9'd0, 8'h80, 10'd0);
        send_item(CMD_TEXT, 9'sd120, 9'sd58, 2'd0, 9'd9, 8'h00, 10'd0);
        send_item(CMD_DRAW, 9'sd0, 9'sd0, 2'd0, 9'd0, "A", 10'd0);
        send_item(CMD_DRAW, 9'sd0, 9'sd0, 2'd0, 9'd0, "z", 10'd0);
        send_item(CMD_DRAW, 9'sd0, 9'sd0, 2'd0, 9'd0, "9", 10'd0);
        send_item(CMD_TEXT, 9'sd10, 9'sd20, 2'd1, 9'd0, 8'h00, 10'd0);
        send_item(CMD_DRAW, 9'sd0, 9'sd0, 2'd0, 9'd0, "a", 10'd0);
        send_item(CMD_TEXT, 9'sd10, 9'sd20, 2'd2, 9'd5, 8'h00, 10'd0);
        send_item(CMD_DRAW, 9'sd0, 9'sd0, 2'd0, 9'd0, "0", 10'd0);
        send_item(CMD_READ, 9'sd0, 9'sd0, 2'd0, 9'd0, 8'h00, 10'd394);
        send_item(3'd7, 9'sd255, -9'sd1, 2'd3, 9'd511, 8'hff, 10'd1023);
        send_item(CMD_CLEAR, 9'sd0, 9'sd0, 2'd0, 9'd0, 8'h00, 10'd0);
        send_item(CMD_READ, 9'sd0, 9'sd0, 2'd0, 9'd0, 8'h00, 10'd394);

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 28 : (phase == 1) ? 70 : 0;
            for (int n = 0; n < 650; n++)
            begin
                if (n == 300)
                begin
                    start <= 1'b0;
                    while (sb.pending.size() != 0) @(posedge clk);
                end
                send_random_item();
            end
        end

        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("scaled_font_text_renderer_top_tb: clean");
        else
            $display("scaled_font_text_renderer_top_tb: errors");
        $finish;
    end
endmodule
